### rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int unsigned PAGE_IN_W = 16;
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned TOTAL_W   = 32;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned EVPAGE_W  = 16;
    localparam int unsigned RESULT_W  = 88;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // lowest bit first: hit, slot, evicted, evicted_page, hit_count, fault_count, pad
    typedef struct packed {
        logic [1:0]          pad;
        logic [TOTAL_W-1:0]  fault_count;
        logic [TOTAL_W-1:0]  hit_count;
        logic [EVPAGE_W-1:0] evicted_page;
        logic                evicted;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
    } t_result;

endpackage

### rtl/lfu_page_replacement.sv
// LFU page replacement, least recently used frame wins a count tie.
// One reference at a time: input is accepted only when idle, after the previous
// result is loaded; a single compare unit scans the page and count memories of
// the active frames one frame per cycle, then updates the chosen frame on load.
// Reset (i_rst_n, synchronous, active low): all frames empty, totals zero,
// frames_in_use 16. Frame contents need no clearing.
module lfu_page_replacement #(
    parameter int unsigned FRAMES    = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [lfu_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lfu_pkg::PAGE_IN_W-1:0]       s_axis_tdata,  // page
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit, slot, evicted, evicted_page, hit_count, fault_count, zero pad
    output logic [lfu_pkg::RESULT_W-1:0]        m_axis_tdata
);
    import lfu_pkg::*;

    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned CW = $clog2(FRAMES + 1);

    t_state                 r_state;
    logic [CFG_W-1:0]       r_frames;
    logic [PAGE_BITS-1:0]   r_page;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_idx;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_idx;
    logic                   r_found;
    logic [IW-1:0]          r_hit_slot;
    logic [COUNT_W-1:0]     r_hit_cnt;
    logic [IW-1:0]          r_hit_rank;
    logic [IW-1:0]          r_best_slot;
    logic [COUNT_W-1:0]     r_best_cnt;
    logic [IW-1:0]          r_best_rank;
    logic [PAGE_BITS-1:0]   r_best_page;
    logic [FRAMES-1:0]      r_valid;
    logic [IW-1:0]          r_rank [FRAMES];
    logic [CW-1:0]          r_filled;
    logic [TOTAL_W-1:0]     r_hits;
    logic [TOTAL_W-1:0]     r_faults;
    logic                   r_out_vld;
    t_result                r_out;
    logic [PAGE_BITS-1:0]   r_q_page;
    logic [COUNT_W-1:0]     r_q_count;

    logic [PAGE_BITS-1:0]   m_page  [FRAMES];
    logic [COUNT_W-1:0]     m_count [FRAMES];

    logic [PAGE_BITS+PAGE_IN_W-1:0] w_in_ext;
    logic [PAGE_BITS+EVPAGE_W-1:0]  w_ev_ext;
    logic [IW+SLOT_W-1:0]           w_slot_ext;
    logic [31:0]            w_n32;
    logic                   w_accept;
    logic                   w_issue;
    logic                   w_last;
    logic                   w_match;
    logic                   w_better;
    logic                   w_fill;
    logic                   w_load;
    logic [IW-1:0]          w_slot;
    logic [IW-1:0]          w_old;
    logic [IW-1:0]          w_cur_rank;
    logic [COUNT_W-1:0]     w_new_cnt;
    logic [TOTAL_W-1:0]     n_hits;
    logic [TOTAL_W-1:0]     n_faults;

    assign w_in_ext = {{PAGE_BITS{1'b0}}, s_axis_tdata};

    always_comb begin
        w_n32 = {{(32-CFG_W){1'b0}}, r_frames};
        if (w_n32 == 32'd0) begin
            w_n32 = 32'd1;
        end else if (w_n32 > FRAMES) begin
            w_n32 = FRAMES;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_issue       = (r_state == S_SCAN) && (r_idx < r_n);
    assign w_last        = r_rd_vld && (CW'(r_rd_idx) == r_n - 1'b1);
    assign w_cur_rank    = r_rank[r_rd_idx];
    assign w_match       = r_valid[r_rd_idx] && (r_q_page == r_page);
    assign w_better      = (r_rd_idx == '0) || (r_q_count < r_best_cnt) ||
                           ((r_q_count == r_best_cnt) && (w_cur_rank > r_best_rank));
    assign w_fill        = !r_found && (r_filled < r_n);
    assign w_load        = (r_state == S_DONE) && (!r_out_vld || m_axis_tready);

    always_comb begin
        if (r_found) begin
            w_slot = r_hit_slot;
            w_old  = r_hit_rank;
        end else if (w_fill) begin
            w_slot = r_filled[IW-1:0];
            w_old  = r_filled[IW-1:0];
        end else begin
            w_slot = r_best_slot;
            w_old  = r_best_rank;
        end
        if (r_found) begin
            w_new_cnt = (r_hit_cnt != COUNT_MAX) ? r_hit_cnt + 1'b1 : r_hit_cnt;
        end else begin
            w_new_cnt = '0;
        end
        n_hits   = (r_found && r_hits != TOTAL_MAX) ? r_hits + 1'b1 : r_hits;
        n_faults = (!r_found && r_faults != TOTAL_MAX) ? r_faults + 1'b1 : r_faults;
    end

    assign w_ev_ext   = {{EVPAGE_W{1'b0}}, r_best_page};
    assign w_slot_ext = {{SLOT_W{1'b0}}, w_slot};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frames  <= CFG_RESET;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_filled  <= '0;
            r_hits    <= '0;
            r_faults  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_frames <= i_cfg_wdata;
            end
            r_rd_vld <= w_issue;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_load) begin
                r_out_vld <= 1'b1;
                r_hits    <= n_hits;
                r_faults  <= n_faults;
                if (w_fill) begin
                    r_valid[w_slot] <= 1'b1;
                    r_filled        <= r_filled + 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page  <= w_in_ext[PAGE_BITS-1:0];
            r_n     <= w_n32[CW-1:0];
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (w_issue) begin
            r_idx    <= r_idx + 1'b1;
            r_rd_idx <= r_idx[IW-1:0];
        end
        if (r_rd_vld) begin
            if (!r_found && w_match) begin
                r_found    <= 1'b1;
                r_hit_slot <= r_rd_idx;
                r_hit_cnt  <= r_q_count;
                r_hit_rank <= w_cur_rank;
            end
            if (w_better) begin
                r_best_slot <= r_rd_idx;
                r_best_cnt  <= r_q_count;
                r_best_rank <= w_cur_rank;
                r_best_page <= r_q_page;
            end
        end
        if (w_load) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (IW'(i) == w_slot) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (r_rank[i] < w_old)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_out.pad          <= '0;
            r_out.hit          <= r_found;
            r_out.slot         <= w_slot_ext[SLOT_W-1:0];
            r_out.evicted      <= !r_found && !w_fill;
            r_out.evicted_page <= (!r_found && !w_fill) ? w_ev_ext[EVPAGE_W-1:0] : '0;
            r_out.hit_count    <= n_hits;
            r_out.fault_count  <= n_faults;
        end
    end

    // frame page and use count memories
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_q_page  <= m_page[r_idx[IW-1:0]];
            r_q_count <= m_count[r_idx[IW-1:0]];
        end
        if (w_load) begin
            m_count[w_slot] <= w_new_cnt;
            if (!r_found) begin
                m_page[w_slot] <= r_page;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

`ifndef ASSERT_OFF
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("transfer in did not start a scan");

    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_filled) <= CW'(FRAMES))
        else $error("filled frame count out of range");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_filled))
        else $error("valid bits disagree with fill count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out.hit && r_out.evicted))
        else $error("hit result marked as eviction");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && r_out_vld)
        else $error("result load did not return to idle");
`endif

endmodule
